>>> hw/rtl/sma_pkg.sv
// ----------------------------------------------------------------------------
// sma_pkg
// shared types and constants of the moving average block
// ----------------------------------------------------------------------------
package sma_pkg;

	localparam int unsigned WINDOW_MAX = 256;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned LEN_W      = $clog2(WINDOW_MAX) + 1;
	localparam int unsigned IDX_W      = $clog2(WINDOW_MAX);
	localparam int unsigned SUM_W      = DATA_W + IDX_W;
	localparam int unsigned STATUS_W   = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

	typedef struct packed {
		logic                     sample_is_null;
		logic signed [DATA_W-1:0] sample_value;
	} in_beat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] average;
		logic [STATUS_W-1:0]      status;
	} out_beat_t;

endpackage

>>> hw/rtl/sma_div.sv
// ----------------------------------------------------------------------------
// sma_div
// radix-2 restoring divider, signed sum by unsigned window length, one
// quotient bit per cycle, quotient truncated toward zero
// ----------------------------------------------------------------------------
module sma_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [sma_pkg::SUM_W-1:0]  dividend,
	input  logic [sma_pkg::LEN_W-1:0]         divisor,
	output logic                              done,
	output logic signed [sma_pkg::DATA_W-1:0] quotient
);

	localparam int unsigned STEPS = sma_pkg::SUM_W;
	localparam int unsigned CNT_W = $clog2(STEPS);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       neg_q;
	logic [sma_pkg::LEN_W-1:0]  div_q;
	logic [sma_pkg::LEN_W-1:0]  rem_q;
	logic [sma_pkg::SUM_W-1:0]  quo_q;

	logic [sma_pkg::LEN_W:0]    trial;
	logic                       fits;
	logic [sma_pkg::LEN_W:0]    diff;
	logic [sma_pkg::SUM_W-1:0]  mag;
	logic [sma_pkg::SUM_W-1:0]  quo_neg;

	assign mag     = dividend[sma_pkg::SUM_W-1] ? (~dividend + sma_pkg::SUM_W'(1))
	                                           : dividend;
	assign trial   = {rem_q, quo_q[sma_pkg::SUM_W-1]};
	assign fits    = trial >= {1'b0, div_q};
	assign diff    = trial - {1'b0, div_q};
	assign quo_neg = ~quo_q + sma_pkg::SUM_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[sma_pkg::SUM_W-1];
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= mag;
		end else if (busy_q) begin
			rem_q <= fits ? diff[sma_pkg::LEN_W-1:0] : trial[sma_pkg::LEN_W-1:0];
			quo_q <= {quo_q[sma_pkg::SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? quo_neg[sma_pkg::DATA_W-1:0] : quo_q[sma_pkg::DATA_W-1:0];

endmodule

>>> hw/rtl/simple_moving_average.sv
// ----------------------------------------------------------------------------
// simple_moving_average
// one beat at a time: a null beat goes from ST_IDLE straight to ST_DONE, a sample
// through ST_READ and ST_SUM to ST_DONE while the window fills, and through ST_DIV too
// once it is full; the next beat is taken only once the result is handed off and ST_IDLE is back
// ST_DIV runs the one-bit-per-cycle divide of the 40-bit running sum
// reset: window length 1, empty stream; ring store contents undefined
// ----------------------------------------------------------------------------
module simple_moving_average (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  sma_pkg::in_beat_t                in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output sma_pkg::out_beat_t               out_data,
	input  logic                             cfg_we,
	input  logic [sma_pkg::LEN_W-1:0]        cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SUM,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                            state_q;
	logic [sma_pkg::LEN_W-1:0]         window_q;
	logic [sma_pkg::IDX_W-1:0]         wr_idx_q;
	logic [sma_pkg::LEN_W-1:0]         count_q;
	logic signed [sma_pkg::SUM_W-1:0]  sum_q;
	logic signed [sma_pkg::DATA_W-1:0] sample_q;
	logic [sma_pkg::IDX_W-1:0]         idx_q;
	sma_pkg::out_beat_t                result_q;
	sma_pkg::out_beat_t                out_data_q;
	logic                              out_valid_q;

	logic signed [sma_pkg::DATA_W-1:0] store [sma_pkg::WINDOW_MAX];
	logic signed [sma_pkg::DATA_W-1:0] rd_data_q;

	logic [sma_pkg::LEN_W-1:0]         len;
	logic                              accept;
	logic                              out_free;
	logic [sma_pkg::IDX_W-1:0]         rd_idx;
	logic                              full_old;
	logic [sma_pkg::LEN_W-1:0]         count_next;
	logic                              full_new;
	logic [sma_pkg::LEN_W-1:0]         idx_inc;
	logic signed [sma_pkg::SUM_W-1:0]  sum_next;
	logic                              div_start;
	logic                              div_done;
	logic signed [sma_pkg::DATA_W-1:0] div_quo;

	always_comb begin
		priority if (window_q == '0) begin
			len = sma_pkg::LEN_W'(1);
		end else if (window_q > sma_pkg::LEN_W'(sma_pkg::WINDOW_MAX)) begin
			len = sma_pkg::LEN_W'(sma_pkg::WINDOW_MAX);
		end else begin
			len = window_q;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign rd_idx     = ({1'b0, wr_idx_q} >= len) ? '0 : wr_idx_q;
	assign full_old   = count_q >= len;
	assign count_next = (count_q < len) ? count_q + sma_pkg::LEN_W'(1) : count_q;
	assign full_new   = count_next >= len;
	assign idx_inc    = {1'b0, idx_q} + sma_pkg::LEN_W'(1);
	assign sum_next   = sum_q + sma_pkg::SUM_W'(sample_q)
	                  - (full_old ? sma_pkg::SUM_W'(rd_data_q) : '0);
	assign div_start  = (state_q == ST_SUM) && full_new;

	// ring store
	always_ff @(posedge clk) begin
		if (state_q == ST_SUM) begin
			store[idx_q] <= sample_q;
		end
		rd_data_q <= store[rd_idx];
	end

	sma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (len),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= sma_pkg::LEN_W'(1);
			wr_idx_q    <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				window_q <= cfg_wdata;
				wr_idx_q <= '0;
				count_q  <= '0;
				sum_q    <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.sample_is_null) begin
							result_q.average <= '0;
							result_q.status  <= (count_q != '0) ? sma_pkg::STATUS_ERROR
							                                    : sma_pkg::STATUS_NULL;
							state_q          <= ST_DONE;
						end else begin
							sample_q <= in_data.sample_value;
							idx_q    <= rd_idx;
							state_q  <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					sum_q    <= sum_next;
					count_q  <= count_next;
					wr_idx_q <= (idx_inc >= len) ? '0 : idx_inc[sma_pkg::IDX_W-1:0];
					if (full_new) begin
						state_q <= ST_DIV;
					end else begin
						result_q.average <= '0;
						result_q.status  <= sma_pkg::STATUS_NULL;
						state_q          <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						result_q.average <= div_quo;
						result_q.status  <= sma_pkg::STATUS_OK;
						state_q          <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_data_q  <= result_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks simple_moving_average against a running-sum predictor of the
// windowed mean: directed null, extreme-sample and window-clamp cases,
// output back-pressure, then random sample streams over many window lengths
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sma_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int ITEM_TARGET  = 1750;
	localparam int DRAIN_CYCLES = 60;
	localparam int IDLE_PERCENT = 13;
	localparam int REPORT_LIMIT = 10;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_beat_t         in_data;
	logic             out_valid;
	logic             out_stall;
	out_beat_t        out_data;
	logic             cfg_we;
	logic [LEN_W-1:0] cfg_wdata;

	// predictor state
	logic [LEN_W-1:0]    window_reg;
	logic signed [31:0]  ring [WINDOW_MAX];
	int unsigned         ring_pos;
	int unsigned         samples_held;
	longint              window_sum;

	out_beat_t expected_averages [$];
	int        failures;
	int        items_sent;
	int        cycle_count;
	int        hold_request;
	bit        quiet_mode;

	simple_moving_average dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void restart_window(input logic [LEN_W-1:0] length);
		window_reg   = length;
		ring_pos     = 0;
		samples_held = 0;
		window_sum   = 0;
	endfunction

	function automatic out_beat_t predict_average(input in_beat_t beat);
		out_beat_t   result;
		int unsigned period;
		int unsigned slot;
		if (window_reg == 0)
			period = 1;
		else if (window_reg > WINDOW_MAX)
			period = WINDOW_MAX;
		else
			period = 32'(window_reg);
		result.average = '0;
		if (beat.sample_is_null) begin
			result.status = (samples_held > 0) ? STATUS_ERROR : STATUS_NULL;
			return result;
		end
		slot = (ring_pos >= period) ? 0 : ring_pos;
		if (samples_held >= period)
			window_sum -= longint'(ring[slot]);
		ring[slot] = beat.sample_value;
		window_sum += longint'($signed(beat.sample_value));
		ring_pos = (slot + 1 >= period) ? 0 : slot + 1;
		if (samples_held < period)
			samples_held++;
		if (samples_held >= period) begin
			result.average = 32'(window_sum / longint'(period));
			result.status  = STATUS_OK;
		end else begin
			result.status = STATUS_NULL;
		end
		return result;
	endfunction

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= REPORT_LIMIT)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// one beat, with a random gap in front of it outside quiet mode; valid stays high afterwards
	task automatic send_beat(input in_beat_t beat);
		@(negedge clk);
		while (!quiet_mode && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		do
			@(posedge clk);
		while (in_stall);
		expected_averages.push_back(predict_average(beat));
		items_sent++;
	endtask

	task automatic send_sample(input logic signed [31:0] value);
		in_beat_t beat;
		beat.sample_is_null = 1'b0;
		beat.sample_value   = value;
		send_beat(beat);
	endtask

	task automatic send_null();
		in_beat_t beat;
		beat.sample_is_null = 1'b1;
		beat.sample_value   = $urandom;
		send_beat(beat);
	endtask

	task automatic write_window(input logic [LEN_W-1:0] length);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_averages.size() != 0)
			@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= length;
		@(negedge clk);
		cfg_we <= 1'b0;
		restart_window(length);
	endtask

	function automatic logic signed [31:0] random_sample();
		logic signed [31:0] value;
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(4))
					0: value = 32'sh7FFF_FFFF;
					1: value = 32'sh8000_0000;
					2: value = -32'sd1;
					3: value = 32'sd1;
					default: value = '0;
				endcase
			end
			1: value = int'($urandom_range(2000)) - 1000;
			default: value = $urandom;
		endcase
		return value;
	endfunction

	task automatic send_random_stream(input int count);
		repeat (count) begin
			if ($urandom_range(19) == 0)
				send_null();
			else
				send_sample(random_sample());
		end
	endtask

	task automatic test_null_handling();
		send_null();
		send_sample(32'sd5);
		send_null();
		write_window(LEN_W'(2));
		send_null();
		send_sample(-32'sd7);
		send_null();
		send_sample(32'sd9);
		send_null();
	endtask

	task automatic test_extreme_samples();
		write_window(LEN_W'(2));
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000);
		send_sample(32'sh8000_0000);
		send_sample(-32'sd1);
		send_sample(-32'sd2);
		write_window(LEN_W'(0));
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000);
		send_sample(32'sd0);
	endtask

	task automatic test_wide_windows();
		write_window(LEN_W'(WINDOW_MAX));
		quiet_mode = 1'b1;
		send_random_stream(300);
		quiet_mode = 1'b0;
		write_window({LEN_W{1'b1}});
		send_random_stream(280);
		write_window(LEN_W'(WINDOW_MAX - 1));
		send_random_stream(270);
	endtask

	task automatic test_back_pressure();
		write_window(LEN_W'(3));
		hold_request = 400;
		send_random_stream(40);
	endtask

	task automatic test_random_windows();
		logic [LEN_W-1:0] length;
		int               period;
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(9))
				0: length = LEN_W'($urandom_range(9, WINDOW_MAX - 1));
				1: length = LEN_W'($urandom_range(WINDOW_MAX, 511));
				2: length = '0;
				default: length = LEN_W'($urandom_range(1, 8));
			endcase
			period = (length == 0) ? 1 : (length > WINDOW_MAX) ? WINDOW_MAX : length;
			write_window(length);
			send_random_stream(period + $urandom_range(5, 40));
		end
	endtask

	// receiver: random stalls, or a counted hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !quiet_mode && ($urandom_range(99) < IDLE_PERCENT);
			end
		end
	end

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_averages.size() == 0) begin
				note_failure($sformatf("unexpected beat: average %0d status %0d",
					out_data.average, out_data.status));
			end else begin
				want = expected_averages.pop_front();
				if (out_data.average !== want.average)
					note_failure($sformatf("average expected %0d got %0d",
						want.average, out_data.average));
				if (out_data.status !== want.status)
					note_failure($sformatf("status expected %0d got %0d",
						want.status, out_data.status));
			end
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		failures     = 0;
		items_sent   = 0;
		hold_request = 0;
		quiet_mode   = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		restart_window(LEN_W'(1));
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_null_handling();
		test_extreme_samples();
		test_back_pressure();
		test_wide_windows();
		test_random_windows();

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_averages.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
